// ===== design/mask_line_rasterizer_macros.svh =====
// Assertion helpers shared by the block's checking code.
`ifndef MASK_LINE_RASTERIZER_MACROS_SVH
`define MASK_LINE_RASTERIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mlr_pkg.sv =====
package mlr_pkg;

  // Fixed field widths.
  localparam int PIX_W   = 6;
  localparam int COORD_W = 16;
  localparam int SCALE_W = 16;
  localparam int CFG_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int SLOPE_W = FRAC_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int VP_W    = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_PLANE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_U   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_V   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_U    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_V    = 3'd4;

  // View plane codes; any other code uses axes 0 and 1.
  localparam logic [VP_W-1:0] VP_AXES_1_2 = 2'd0;
  localparam logic [VP_W-1:0] VP_AXES_0_2 = 2'd1;
  localparam logic [VP_W-1:0] VP_AXES_0_1 = 2'd2;

  // Reset values of the registers.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  // One half in Q.16.
  localparam logic [FRAC_W-1:0] Q16_HALF = 16'h8000;

  // Line direction handed from the sequencer to the stepper.
  typedef struct packed {
    logic u_major;    // u is the major axis
    logic major_dec;  // major index counts down
    logic slope_neg;  // minor index moves down
  } dda_ctl_t;

endpackage

// ===== design/mlr_map.sv =====
module mlr_map #(
  parameter int GRID_SIZE = 64,
  parameter int IDX_W     = 6
) (
  input  logic                              clk,
  input  logic signed [mlr_pkg::COORD_W-1:0] coord,
  input  logic signed [mlr_pkg::COORD_W-1:0] origin,
  input  logic        [mlr_pkg::SCALE_W-1:0] scale,
  output logic        [IDX_W-1:0]            idx
);
  import mlr_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + SCALE_W + 1;
  localparam int Q_W    = PROD_W - 1 - FRAC_W;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] product_r;
  logic signed [PROD_W-1:0] sum;
  logic        [Q_W-1:0]    q;

  // Offset from the origin times the scale, registered.
  assign diff = DIFF_W'(coord) - DIFF_W'(origin);

  always_ff @(posedge clk) begin
    product_r <= PROD_W'(diff * $signed({1'b0, scale}));
  end

  // Round half up, then clamp to the grid.
  assign sum = product_r + PROD_W'(Q16_HALF);
  assign q   = sum[PROD_W-2:FRAC_W];

  always_comb begin
    if (sum[PROD_W-1]) begin
      idx = '0;
    end else if (q > Q_W'(GRID_SIZE - 1)) begin
      idx = IDX_W'(GRID_SIZE - 1);
    end else begin
      idx = q[IDX_W-1:0];
    end
  end

endmodule

// ===== design/mlr_div.sv =====
module mlr_div #(
  parameter int IDX_W = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [IDX_W-1:0]              num,
  input  logic [IDX_W-1:0]              den,
  output logic                          done,
  output logic [mlr_pkg::SLOPE_W-1:0]   quot
);
  import mlr_pkg::*;

  localparam int NUM_W = IDX_W + FRAC_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] shift_r, shift_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W:0]   trial;
  logic             fits;

  // One restoring step per cycle: the remainder takes the next numerator bit.
  assign trial = {rem_r, shift_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = {num, FRAC_W'(0)};
      rem_nxt   = '0;
      cnt_nxt   = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt   = fits ? IDX_W'(trial - {1'b0, den_r}) : trial[IDX_W-1:0];
      shift_nxt = {shift_r[NUM_W-2:0], fits};
      cnt_nxt   = cnt_r - 1'b1;
      done_nxt  = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  // The quotient never exceeds one in Q.16.
  assign quot = shift_r[SLOPE_W-1:0];
  assign done = done_r;

endmodule

// ===== design/mlr_dda.sv =====
module mlr_dda #(
  parameter int IDX_W = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  mlr_pkg::dda_ctl_t           ctl,
  input  logic [IDX_W-1:0]            x0,
  input  logic [IDX_W-1:0]            y0,
  input  logic [IDX_W-1:0]            major_end,
  input  logic [mlr_pkg::SLOPE_W-1:0] slope_mag,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [IDX_W-1:0]            pix_x,
  output logic [IDX_W-1:0]            pix_y,
  output logic                        last,
  output logic                        done
);
  import mlr_pkg::*;

  localparam int ACC_W = IDX_W + FRAC_W;

  dda_ctl_t         ctl_r;
  logic [IDX_W-1:0] end_r;
  logic [ACC_W-1:0] slope_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic             last_r, last_nxt;
  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] maj, maj_step, minor0;
  logic             advance;

  assign advance  = valid_r && !out_stall;
  assign maj      = ctl_r.u_major ? x_r : y_r;
  assign maj_step = ctl_r.major_dec ? maj - 1'b1 : maj + 1'b1;
  assign minor0   = ctl.u_major ? y0 : x0;

  // Load the start pixel, then take one step each time a pixel is taken.
  always_comb begin
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    last_nxt  = last_r;
    valid_nxt = valid_r;
    if (start) begin
      acc_nxt   = {minor0, Q16_HALF};
      x_nxt     = x0;
      y_nxt     = y0;
      last_nxt  = ((ctl.u_major ? x0 : y0) == major_end);
      valid_nxt = 1'b1;
    end else if (advance) begin
      if (last_r) begin
        valid_nxt = 1'b0;
      end else begin
        acc_nxt  = ctl_r.slope_neg ? acc_r - slope_r : acc_r + slope_r;
        last_nxt = (maj_step == end_r);
        if (ctl_r.u_major) begin
          x_nxt = maj_step;
          y_nxt = acc_nxt[ACC_W-1:FRAC_W];
        end else begin
          x_nxt = acc_nxt[ACC_W-1:FRAC_W];
          y_nxt = maj_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    last_r <= last_nxt;
    if (start) begin
      ctl_r   <= ctl;
      end_r   <= major_end;
      slope_r <= ACC_W'(slope_mag);
    end
  end

  assign out_valid = valid_r;
  assign pix_x     = x_r;
  assign pix_y     = y_r;
  assign last      = last_r;
  assign done      = advance && last_r;

endmodule

// ===== design/mask_line_rasterizer.sv =====
// Rasterizes one add-line or remove-line request into pixel writes for a
// pair of masks. After an item is accepted, a single multiplier maps the
// four in-plane coordinates to grid indices one per cycle, the setup state
// sorts out the major axis, a bit-serial divider forms the Q.16 slope
// (skipped when start and end pixel match), and the stepper then emits one
// pixel per cycle while out_stall is low, 1 + max(|du|,|dv|) pixels in all;
// in_stall stays high until the last pixel is taken.
`include "mask_line_rasterizer_macros.svh"

module mask_line_rasterizer #(
  parameter int GRID_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration writes.
  input  logic                                cfg_we,
  input  logic [mlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlr_pkg::CFG_W-1:0]           cfg_data,
  // Line requests.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [mlr_pkg::COORD_W-1:0]  in_start_axis0,
  input  logic signed [mlr_pkg::COORD_W-1:0]  in_start_axis1,
  input  logic signed [mlr_pkg::COORD_W-1:0]  in_start_axis2,
  input  logic signed [mlr_pkg::COORD_W-1:0]  in_end_axis0,
  input  logic signed [mlr_pkg::COORD_W-1:0]  in_end_axis1,
  input  logic signed [mlr_pkg::COORD_W-1:0]  in_end_axis2,
  // Pixel writes.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mlr_pkg::PIX_W-1:0]           out_pixel_x,
  output logic [mlr_pkg::PIX_W-1:0]           out_pixel_y,
  output logic                                out_write_value,
  output logic                                out_to_add_mask,
  output logic                                out_to_remove_mask,
  output logic                                out_last
);
  import mlr_pkg::*;

  localparam int IDX_W = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DRAW  = 3'd4;

  // Configuration registers.
  logic        [VP_W-1:0]    view_plane_r;
  logic signed [COORD_W-1:0] origin_u_r, origin_v_r;
  logic        [SCALE_W-1:0] scale_u_r, scale_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_plane_r <= VP_AXES_0_1;
      origin_u_r   <= '0;
      origin_v_r   <= '0;
      scale_u_r    <= SCALE_RESET;
      scale_v_r    <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIEW_PLANE: view_plane_r <= cfg_data[VP_W-1:0];
        CFG_ORIGIN_U:   origin_u_r   <= cfg_data;
        CFG_ORIGIN_V:   origin_v_r   <= cfg_data;
        CFG_SCALE_U:    scale_u_r    <= cfg_data;
        CFG_SCALE_V:    scale_v_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2:0] state_r, state_nxt;
  logic [2:0] map_cnt_r, map_cnt_nxt;
  logic       in_accept;

  // No item is taken while reset is held or a line is in progress.
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Capture the in-plane coordinates of the item as it is accepted.
  logic signed [COORD_W-1:0] su_r, sv_r, eu_r, ev_r;
  logic                      func_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= in_func;
      case (view_plane_r)
        VP_AXES_1_2: begin
          su_r <= in_start_axis1;
          sv_r <= in_start_axis2;
          eu_r <= in_end_axis1;
          ev_r <= in_end_axis2;
        end
        VP_AXES_0_2: begin
          su_r <= in_start_axis0;
          sv_r <= in_start_axis2;
          eu_r <= in_end_axis0;
          ev_r <= in_end_axis2;
        end
        default: begin
          su_r <= in_start_axis0;
          sv_r <= in_start_axis1;
          eu_r <= in_end_axis0;
          ev_r <= in_end_axis1;
        end
      endcase
    end
  end

  // Shared mapping multiplier: start u, start v, end u, end v in turn.
  logic signed [COORD_W-1:0] map_coord, map_origin;
  logic        [SCALE_W-1:0] map_scale;
  logic        [IDX_W-1:0]   map_idx;

  always_comb begin
    case (map_cnt_r[1:0])
      2'd0:    map_coord = su_r;
      2'd1:    map_coord = sv_r;
      2'd2:    map_coord = eu_r;
      default: map_coord = ev_r;
    endcase
    map_origin = map_cnt_r[0] ? origin_v_r : origin_u_r;
    map_scale  = map_cnt_r[0] ? scale_v_r  : scale_u_r;
  end

  mlr_map #(
    .GRID_SIZE (GRID_SIZE),
    .IDX_W     (IDX_W)
  ) u_map (
    .clk    (clk),
    .coord  (map_coord),
    .origin (map_origin),
    .scale  (map_scale),
    .idx    (map_idx)
  );

  // Indices arrive in the cycle after their operands.
  logic [IDX_W-1:0] x0_r, y0_r, x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_MAP) begin
      case (map_cnt_r)
        3'd1:    x0_r <= map_idx;
        3'd2:    y0_r <= map_idx;
        3'd3:    x1_r <= map_idx;
        3'd4:    y1_r <= map_idx;
        default: ;
      endcase
    end
  end

  // Line lengths and direction.
  logic [IDX_W-1:0] adx, ady, major_len, minor_len, major_end;
  logic             dx_neg, dy_neg;
  dda_ctl_t         ctl;

  assign dx_neg    = x1_r < x0_r;
  assign dy_neg    = y1_r < y0_r;
  assign adx       = dx_neg ? x0_r - x1_r : x1_r - x0_r;
  assign ady       = dy_neg ? y0_r - y1_r : y1_r - y0_r;
  assign ctl.u_major   = adx > ady;
  assign ctl.major_dec = ctl.u_major ? dx_neg : dy_neg;
  assign ctl.slope_neg = ctl.u_major ? dy_neg : dx_neg;
  assign major_len = ctl.u_major ? adx : ady;
  assign minor_len = ctl.u_major ? ady : adx;
  assign major_end = ctl.u_major ? x1_r : y1_r;

  logic               div_start, div_done;
  logic [SLOPE_W-1:0] div_quot;
  logic               dda_start, dda_done;
  logic               dda_valid, dda_last;
  logic [IDX_W-1:0]   dda_x, dda_y;

  mlr_div #(
    .IDX_W (IDX_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (minor_len),
    .den   (major_len),
    .done  (div_done),
    .quot  (div_quot)
  );

  mlr_dda #(
    .IDX_W (IDX_W)
  ) u_dda (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dda_start),
    .ctl       (ctl),
    .x0        (x0_r),
    .y0        (y0_r),
    .major_end (major_end),
    .slope_mag (div_quot),
    .out_stall (out_stall),
    .out_valid (dda_valid),
    .pix_x     (dda_x),
    .pix_y     (dda_y),
    .last      (dda_last),
    .done      (dda_done)
  );

  // Sequencer: map, set up, divide unless start and end pixel match, then draw.
  always_comb begin
    state_nxt   = state_r;
    map_cnt_nxt = map_cnt_r;
    div_start   = 1'b0;
    dda_start   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt   = ST_MAP;
          map_cnt_nxt = '0;
        end
      end
      ST_MAP: begin
        map_cnt_nxt = map_cnt_r + 1'b1;
        if (map_cnt_r == 3'd4) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (major_len == '0) begin
          dda_start = 1'b1;
          state_nxt = ST_DRAW;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          dda_start = 1'b1;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (dda_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      map_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      map_cnt_r <= map_cnt_nxt;
    end
  end

  // Pixel write outputs.
  assign out_valid          = dda_valid;
  assign out_pixel_x        = PIX_W'(dda_x);
  assign out_pixel_y        = PIX_W'(dda_y);
  assign out_write_value    = !func_r;
  assign out_to_add_mask    = !func_r;
  assign out_to_remove_mask = 1'b1;
  assign out_last           = dda_last;

  // Checks on the sequencer and stepper.
  `MLR_ASSERT_NOW(a_no_pixel_when_idle, clk, rst_n, (state_r != ST_DRAW), !out_valid, "pixel write outside drawing")
  `MLR_ASSERT_NEXT(a_idle_after_last, clk, rst_n, (out_valid && !out_stall && out_last), (state_r == ST_IDLE), "block not idle after last pixel")
  `MLR_ASSERT_NOW(a_pixel_in_grid, clk, rst_n, out_valid, ((out_pixel_x <= PIX_W'(GRID_SIZE - 1)) && (out_pixel_y <= PIX_W'(GRID_SIZE - 1))), "pixel outside grid")

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import mlr_pkg::*;

  localparam int GRID = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;

  // Line operations carried in the func field.
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // View plane code that the package leaves unnamed; it behaves as axes 0 and 1.
  localparam logic [VP_W-1:0] VP_UNUSED = 2'd3;

  // A register index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One line request as driven on the input channel.
  typedef struct packed {
    logic         func;
    coord_t [2:0] start_pt;
    coord_t [2:0] end_pt;
  } line_req_t;

  // One pixel write as seen on the result channel.
  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             wval;
    logic             to_add;
    logic             to_rem;
    logic             last;
  } pixel_wr_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_func = 1'b0;
  coord_t in_start_axis0 = '0;
  coord_t in_start_axis1 = '0;
  coord_t in_start_axis2 = '0;
  coord_t in_end_axis0 = '0;
  coord_t in_end_axis1 = '0;
  coord_t in_end_axis2 = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_pixel_x;
  logic [PIX_W-1:0] out_pixel_y;
  logic             out_write_value;
  logic             out_to_add_mask;
  logic             out_to_remove_mask;
  logic             out_last;

  // Our own copy of the configuration registers, at their reset values.
  logic [VP_W-1:0]    plane_reg = VP_AXES_0_1;
  coord_t             org_u = '0;
  coord_t             org_v = '0;
  logic [SCALE_W-1:0] scale_u = SCALE_RESET;
  logic [SCALE_W-1:0] scale_v = SCALE_RESET;

  pixel_wr_t   pixel_q[$];
  pixel_wr_t   want_wr;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  mask_line_rasterizer #(
    .GRID_SIZE(GRID)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_start_axis0     (in_start_axis0),
    .in_start_axis1     (in_start_axis1),
    .in_start_axis2     (in_start_axis2),
    .in_end_axis0       (in_end_axis0),
    .in_end_axis1       (in_end_axis1),
    .in_end_axis2       (in_end_axis2),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_write_value    (out_write_value),
    .out_to_add_mask    (out_to_add_mask),
    .out_to_remove_mask (out_to_remove_mask),
    .out_last           (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The view plane decides which world axes become the column and the row.
  function automatic void plane_axes(input logic [VP_W-1:0] plane, output int ua,
                                     output int va);
    if (plane == VP_AXES_1_2) begin
      ua = 1;
      va = 2;
    end else if (plane == VP_AXES_0_2) begin
      ua = 0;
      va = 2;
    end else begin
      ua = 0;
      va = 1;
    end
  endfunction

  // Maps a world coordinate to a grid index: round half up, then saturate.
  function automatic int grid_index(coord_t coord, coord_t origin, logic [SCALE_W-1:0] scale);
    longint prod;
    prod = (longint'(coord) - longint'(origin)) * longint'(scale) + 32768;
    if (prod < 0) return 0;
    prod = prod >>> FRAC_W;
    if (prod > GRID - 1) return GRID - 1;
    return int'(prod);
  endfunction

  function automatic void push_pixel(int x, int y, logic rm, logic is_last);
    pixel_wr_t wr;
    wr.x = x[PIX_W-1:0];
    wr.y = y[PIX_W-1:0];
    wr.wval = !rm;
    wr.to_add = !rm;
    wr.to_rem = 1'b1;
    wr.last = is_last;
    pixel_q.push_back(wr);
  endfunction

  // Works out every pixel write of one line: the start pixel, then one per DDA step.
  function automatic void predict_line(line_req_t req);
    int ua, va, x0, y0, x1, y1, dx, dy, adx, ady, major_step, slope, acc;
    logic rm;
    plane_axes(plane_reg, ua, va);
    rm = (req.func == FUNC_REMOVE);
    x0 = grid_index(req.start_pt[ua], org_u, scale_u);
    y0 = grid_index(req.start_pt[va], org_v, scale_v);
    x1 = grid_index(req.end_pt[ua], org_u, scale_u);
    y1 = grid_index(req.end_pt[va], org_v, scale_v);
    dx = x1 - x0;
    dy = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    push_pixel(x0, y0, rm, dx == 0 && dy == 0);
    if (adx > ady) begin
      // Column is the major axis; the row follows the Q.16 accumulator.
      major_step = (dx < 0) ? -1 : 1;
      slope = (ady << FRAC_W) / adx;
      if (dy < 0) slope = -slope;
      acc = y0 * 65536 + 32768;
      while (x0 != x1) begin
        x0 += major_step;
        acc += slope;
        push_pixel(x0, acc >>> FRAC_W, rm, x0 == x1);
      end
    end else if (ady != 0) begin
      // Row is the major axis, also when both distances are equal.
      major_step = (dy < 0) ? -1 : 1;
      slope = (adx << FRAC_W) / ady;
      if (dx < 0) slope = -slope;
      acc = x0 * 65536 + 32768;
      while (y0 != y1) begin
        y0 += major_step;
        acc += slope;
        push_pixel(acc >>> FRAC_W, y0, rm, y0 == y1);
      end
    end
  endfunction

  // Picks a world coordinate that lands near the given grid index.
  function automatic coord_t grid_coord(int idx, coord_t origin, logic [SCALE_W-1:0] scale);
    longint c;
    if (scale == 0) return 16'($urandom);
    c = longint'(origin) +
        (longint'(idx) * 65536 - 32768 + longint'($urandom_range(0, 65535))) / longint'(scale);
    if (c < -32768) c = -32768;
    else if (c > 32767) c = 32767;
    return c[COORD_W-1:0];
  endfunction

  function automatic line_req_t random_req();
    line_req_t req;
    int i;
    req.func = 1'($urandom);
    for (i = 0; i < 3; i++) begin
      req.start_pt[i] = 16'($urandom);
      req.end_pt[i] = 16'($urandom);
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  // Sends one item. The sender works in bursts and idles at random between them.
  task automatic send_line(line_req_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_func <= req.func;
    in_start_axis0 <= req.start_pt[0];
    in_start_axis1 <= req.start_pt[1];
    in_start_axis2 <= req.start_pt[2];
    in_end_axis0 <= req.end_pt[0];
    in_end_axis1 <= req.end_pt[1];
    in_end_axis2 <= req.end_pt[2];
    do @(posedge clk); while (in_stall);
    predict_line(req);
    burst_left--;
  endtask

  // Sends a line given by its in-plane coordinates; the third axis is random.
  task automatic send_uv(logic func, coord_t su, coord_t sv, coord_t eu, coord_t ev);
    line_req_t req;
    int ua, va;
    req = random_req();
    req.func = func;
    plane_axes(plane_reg, ua, va);
    req.start_pt[ua] = su;
    req.start_pt[va] = sv;
    req.end_pt[ua] = eu;
    req.end_pt[va] = ev;
    send_line(req);
  endtask

  // Stops sending and waits until every pending pixel write has come out.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_VIEW_PLANE: plane_reg = data[VP_W-1:0];
      CFG_ORIGIN_U:   org_u = data;
      CFG_ORIGIN_V:   org_v = data;
      CFG_SCALE_U:    scale_u = data;
      CFG_SCALE_V:    scale_v = data;
      default: ;
    endcase
  endtask

  // Rewrites every register once the block has gone idle.
  task automatic write_config(logic [VP_W-1:0] plane, coord_t ou, coord_t ov,
                              logic [SCALE_W-1:0] su, logic [SCALE_W-1:0] sv);
    drain();
    write_reg(CFG_VIEW_PLANE, {14'($urandom), plane});
    write_reg(CFG_ORIGIN_U, ou);
    write_reg(CFG_ORIGIN_V, ov);
    write_reg(CFG_SCALE_U, su);
    write_reg(CFG_SCALE_V, sv);
    write_reg(CFG_UNUSED_IDX, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Directed lines at the reset configuration, where pixel i sits at coordinate 16*i.
  task automatic test_reset_defaults();
    send_uv(FUNC_ADD, 80, 80, 80, 80);
    send_uv(FUNC_REMOVE, 80, 80, 87, 73);
    send_uv(FUNC_ADD, 0, 0, 1008, 0);
    send_uv(FUNC_REMOVE, 1008, 1008, 1008, 0);
    send_uv(FUNC_ADD, 0, 0, 1008, 1008);
    send_uv(FUNC_REMOVE, 1008, 0, 0, 1008);
    send_uv(FUNC_ADD, 0, 160, 1008, 320);
    send_uv(FUNC_REMOVE, 800, 640, 48, 480);
    send_uv(FUNC_ADD, 160, 0, 320, 1008);
    send_uv(FUNC_ADD, 640, 960, 480, 32);
    send_uv(FUNC_REMOVE, -32768, -32768, 32767, 32767);
    send_uv(FUNC_ADD, 7, 8, 24, 23);
    send_uv(FUNC_ADD, 32767, -32768, -32768, 32767);
  endtask

  // Each remaining view plane code, including the unused one.
  task automatic test_view_planes();
    logic [VP_W-1:0] plane;
    int i;
    for (i = 0; i < 3; i++) begin
      plane = (i == 0) ? VP_AXES_1_2 : (i == 1) ? VP_AXES_0_2 : VP_UNUSED;
      write_config(plane, -160, 80, 16'd4096, 16'd8192);
      send_uv(FUNC_ADD, grid_coord(2, org_u, scale_u), grid_coord(50, org_v, scale_v),
              grid_coord(60, org_u, scale_u), grid_coord(10, org_v, scale_v));
      send_uv(FUNC_REMOVE, grid_coord(30, org_u, scale_u), grid_coord(1, org_v, scale_v),
              grid_coord(12, org_u, scale_u), grid_coord(62, org_v, scale_v));
    end
  endtask

  // Zero and full-scale voxel densities with the origins at both ends of their range.
  task automatic test_scale_extremes();
    write_config(VP_AXES_0_1, 16'sh7FFF, 16'sh8000, 16'h0000, 16'hFFFF);
    send_uv(FUNC_ADD, -32768, -32768, 32767, -32728);
    send_uv(FUNC_REMOVE, 0, -32758, 123, 32767);
    write_config(VP_AXES_0_1, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'h0000);
    send_uv(FUNC_ADD, -32763, 0, -32708, 100);
    send_uv(FUNC_REMOVE, 32767, 32767, -32768, -32768);
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 16'($urandom_range(2048, 8192));
    if (pick < 8) return 16'($urandom_range(512, 65535));
    if (pick < 9) return 16'($urandom_range(256, 2048));
    return 16'($urandom);
  endfunction

  // Places the origin so that the whole grid stays within the coordinate range.
  function automatic coord_t pick_origin(logic [SCALE_W-1:0] scale);
    int span;
    span = (scale == 0) ? 0 : (GRID * 65536) / scale;
    if (span > 65535) span = 65535;
    return 16'(-32768 + int'($urandom_range(0, 65535 - span)));
  endfunction

  // Mostly lines inside or near the grid, some short, some full-range noise.
  task automatic send_random_line();
    int kind, u0, v0, u1, v1;
    kind = $urandom_range(0, 9);
    u0 = $urandom_range(0, GRID - 1);
    v0 = $urandom_range(0, GRID - 1);
    if (kind < 2) begin
      send_line(random_req());
    end else begin
      if (kind < 5) begin
        u1 = u0 + $urandom_range(0, 8) - 4;
        v1 = v0 + $urandom_range(0, 8) - 4;
      end else if (kind < 8) begin
        u1 = $urandom_range(0, GRID - 1);
        v1 = $urandom_range(0, GRID - 1);
      end else begin
        u0 = $urandom_range(0, GRID + 15) - 8;
        v0 = $urandom_range(0, GRID + 15) - 8;
        u1 = $urandom_range(0, GRID + 15) - 8;
        v1 = $urandom_range(0, GRID + 15) - 8;
      end
      send_uv(1'($urandom), grid_coord(u0, org_u, scale_u), grid_coord(v0, org_v, scale_v),
              grid_coord(u1, org_u, scale_u), grid_coord(v1, org_v, scale_v));
    end
  endtask

  task automatic test_random_lines();
    int phase, n;
    logic [SCALE_W-1:0] su, sv;
    for (phase = 0; phase < 6; phase++) begin
      su = pick_scale();
      sv = pick_scale();
      write_config(2'($urandom), pick_origin(su), pick_origin(sv), su, sv);
      for (n = 0; n < 35; n++) send_random_line();
    end
  endtask

  // The receiver switches between stall patterns every so often.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  // Each accepted pixel write is compared with the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("pixel write with none pending, pixel_x", out_pixel_x, -1);
      end else begin
        want_wr = pixel_q.pop_front();
        if (out_pixel_x != want_wr.x) report_mismatch("pixel_x", out_pixel_x, want_wr.x);
        if (out_pixel_y != want_wr.y) report_mismatch("pixel_y", out_pixel_y, want_wr.y);
        if (out_write_value != want_wr.wval)
          report_mismatch("write_value", out_write_value, want_wr.wval);
        if (out_to_add_mask != want_wr.to_add)
          report_mismatch("to_add_mask", out_to_add_mask, want_wr.to_add);
        if (out_to_remove_mask != want_wr.to_rem)
          report_mismatch("to_remove_mask", out_to_remove_mask, want_wr.to_rem);
        if (out_last != want_wr.last) report_mismatch("last", out_last, want_wr.last);
      end
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL mask_line_rasterizer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_view_planes();
    test_scale_extremes();
    test_random_lines();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS mask_line_rasterizer");
    end else begin
      $display("FAIL mask_line_rasterizer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mlr_pkg.sv
design/mlr_map.sv
design/mlr_div.sv
design/mlr_dda.sv
design/mask_line_rasterizer.sv
tb/testbench.sv
